### rtl/rvil_pkg.sv
package rvil_pkg;

  localparam int COORD_W     = 32;
  localparam int IDX_W       = 16;
  localparam int SIZE_W      = 31;
  localparam int LEN_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int FRAC_BITS   = 30;
  localparam int DIV_BITS    = FRAC_BITS;
  localparam int DEN_W       = COORD_W + 1;
  localparam int PROD_W      = (IDX_W - 1) + SIZE_W;
  localparam int NUM_W       = PROD_W + 3;
  localparam int SQ_W        = 2 * DEN_W;
  localparam int SUM_W       = SQ_W;
  localparam int T_W         = SUM_W + 1;
  localparam int DIST_W      = 33;
  localparam int CORE_STAGES = (DIST_W > DIV_BITS) ? DIST_W : DIV_BITS;
  localparam int PAR_W       = FRAC_BITS + 1;

  localparam logic [PAR_W-1:0]  ONE_Q      = PAR_W'(1) << FRAC_BITS;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);

  localparam int GRID_X_DEF = 256;
  localparam int GRID_Y_DEF = 256;
  localparam int GRID_Z_DEF = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_ORIGIN_Z,
    CFG_SIZE_X,
    CFG_SIZE_Y,
    CFG_SIZE_Z
  } cfg_reg_t;

  // slab s belongs to axis s/2; even slabs are the low plane
  typedef struct packed {
    logic                          idx_bad;
    logic [2:0]                    moving;
    logic [2:0]                    stat_ok;
    logic [5:0]                    zero;
    logic [5:0]                    one;
    logic [5:0][DEN_W-1:0]         rem;
    logic [5:0][DIV_BITS-1:0]      q;
    logic [2:0][DEN_W-1:0]         den;
    logic [SUM_W-1:0]              srem;
    logic [DIST_W-1:0]             root;
  } item_t;

endpackage

### rtl/ray_voxel_intersection_length.sv
// Length of a ray segment inside one voxel of a regular grid, Q16.16.
// Input channel (in_valid/in_ready) takes segment start, end and a voxel
// index; output channel (out_valid/out_ready) returns segment_length and
// status, one result per request, in order. Status 1 flags an index outside
// the grid, with length 0.
// Config channel (cfg_valid/cfg_ready) writes grid origin and voxel sizes by
// index; cfg_ready is always high. Write only while no request is in flight.
// 3 setup stages, then 33 core stages where each of the six slab dividers
// retires one quotient bit per stage until its quotient is full and the
// square root one result bit per stage, then 5 stages for clamping, the
// length multiply and saturation. One request per cycle if out_ready is high.
// Reset clears the pipeline and sets origin 0 and voxel size 1.0 on each axis.
// When the receiver stalls, the result holds in the output register; earlier
// stages keep filling empty slots, so in_ready drops only once every stage
// holds a request.
module ray_voxel_intersection_length
  import rvil_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   start_x,
  input  logic [COORD_W-1:0]   start_y,
  input  logic [COORD_W-1:0]   start_z,
  input  logic [COORD_W-1:0]   end_x,
  input  logic [COORD_W-1:0]   end_y,
  input  logic [COORD_W-1:0]   end_z,
  input  logic [IDX_W-1:0]     voxel_i,
  input  logic [IDX_W-1:0]     voxel_j,
  input  logic [IDX_W-1:0]     voxel_k,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LEN_W-1:0]     segment_length,
  output logic                 status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  logic [2:0][COORD_W-1:0] origin;
  logic [2:0][SIZE_W-1:0]  size;

  logic  f_valid, f_ready, c_valid, c_ready;
  item_t f_item, c_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      size   <= {SIZE_RESET, SIZE_RESET, SIZE_RESET};
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_X: origin[0] <= cfg_data;
        CFG_ORIGIN_Y: origin[1] <= cfg_data;
        CFG_ORIGIN_Z: origin[2] <= cfg_data;
        CFG_SIZE_X:   size[0]   <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Y:   size[1]   <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Z:   size[2]   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  rvil_front #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .start    ({start_z, start_y, start_x}),
    .stop     ({end_z, end_y, end_x}),
    .idx      ({voxel_k, voxel_j, voxel_i}),
    .origin   (origin),
    .size     (size),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .out_item (f_item)
  );

  rvil_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_item  (f_item),
    .out_valid(c_valid),
    .out_ready(c_ready),
    .out_item (c_item)
  );

  rvil_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (c_valid),
    .in_ready      (c_ready),
    .in_item       (c_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .segment_length(segment_length),
    .status        (status)
  );

endmodule

### rtl/rvil_front.sv
module rvil_front
  import rvil_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0][COORD_W-1:0]     start,
  input  logic [2:0][COORD_W-1:0]     stop,
  input  logic [2:0][IDX_W-1:0]       idx,
  input  logic [2:0][COORD_W-1:0]     origin,
  input  logic [2:0][SIZE_W-1:0]      size,
  output logic                        out_valid,
  input  logic                        out_ready,
  output item_t                       out_item
);

  localparam logic [2:0][IDX_W-1:0] GRID = {IDX_W'(GRID_Z), IDX_W'(GRID_Y), IDX_W'(GRID_X)};

  typedef struct packed {
    logic                      idx_bad;
    logic [2:0]                neg;
    logic [2:0]                moving;
    logic [2:0][DEN_W-1:0]     adiff;
    logic [2:0][DEN_W-1:0]     t;
    logic [2:0][PROD_W-1:0]    prod;
  } s1_t;

  typedef struct packed {
    logic                      idx_bad;
    logic [2:0]                neg;
    logic [2:0]                moving;
    logic [2:0][DEN_W-1:0]     adiff;
    logic [2:0][NUM_W-1:0]     num_a;
    logic [2:0][NUM_W-1:0]     num_b;
    logic [2:0][SQ_W-1:0]      sq;
  } s2_t;

  logic [2:0] v, e;
  s1_t   s1, s1_next;
  s2_t   s2, s2_next;
  item_t s3, s3_next;

  always_comb begin
    e[2] = !v[2] || out_ready;
    e[1] = !v[1] || e[2];
    e[0] = !v[0] || e[1];
  end

  assign in_ready  = e[0];
  assign out_valid = v[2];
  assign out_item  = s3;

  always_comb begin
    logic [DEN_W-1:0] d;
    d = '0;
    s1_next = '0;
    for (int a = 0; a < 3; a++) begin
      d = DEN_W'($signed(stop[a])) - DEN_W'($signed(start[a]));
      s1_next.neg[a]    = d[DEN_W-1];
      s1_next.adiff[a]  = d[DEN_W-1] ? DEN_W'(-d) : d;
      s1_next.moving[a] = (d != '0);
      s1_next.t[a]      = DEN_W'($signed(origin[a])) - DEN_W'($signed(start[a]));
      s1_next.prod[a]   = PROD_W'(idx[a][IDX_W-2:0]) * PROD_W'(size[a]);
      if (idx[a] >= GRID[a]) begin
        s1_next.idx_bad = 1'b1;
      end
    end
  end

  always_comb begin
    s2_next.idx_bad = s1.idx_bad;
    s2_next.neg     = s1.neg;
    s2_next.moving  = s1.moving;
    s2_next.adiff   = s1.adiff;
    for (int a = 0; a < 3; a++) begin
      s2_next.num_a[a] = NUM_W'($signed(s1.t[a])) + NUM_W'(s1.prod[a]);
      s2_next.num_b[a] = NUM_W'($signed(s1.t[a])) + NUM_W'(s1.prod[a]) + NUM_W'(size[a]);
      s2_next.sq[a]    = SQ_W'(s1.adiff[a]) * SQ_W'(s1.adiff[a]);
    end
  end

  always_comb begin
    logic [NUM_W-1:0] n;
    logic [NUM_W-1:0] nn;
    n  = '0;
    nn = '0;
    s3_next = '0;
    s3_next.idx_bad = s2.idx_bad;
    s3_next.moving  = s2.moving;
    s3_next.den     = s2.adiff;
    s3_next.srem    = s2.sq[0] + s2.sq[1] + s2.sq[2];
    for (int a = 0; a < 3; a++) begin
      s3_next.stat_ok[a] = $signed(s2.num_a[a]) < 0 && $signed(s2.num_b[a]) >= 0;
    end
    for (int s = 0; s < 6; s++) begin
      n  = s[0] ? s2.num_b[s/2] : s2.num_a[s/2];
      nn = s2.neg[s/2] ? NUM_W'(-n) : n;
      s3_next.zero[s] = $signed(nn) <= 0;
      s3_next.one[s]  = $signed(nn) >= $signed(NUM_W'(s2.adiff[s/2]));
      s3_next.rem[s]  = nn[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (e[0]) v[0] <= in_valid;
      if (e[1]) v[1] <= v[0];
      if (e[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (e[0]) s1 <= s1_next;
    if (e[1]) s2 <= s2_next;
    if (e[2]) s3 <= s3_next;
  end

endmodule

### rtl/rvil_core.sv
module rvil_core
  import rvil_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  localparam int N = CORE_STAGES;

  // one quotient bit per slab in each of the first DIV_BITS stages and one root bit per stage
  function automatic item_t step(item_t x, int unsigned i);
    item_t            y;
    logic [DEN_W:0]   r2;
    logic [DEN_W:0]   dd;
    logic [T_W-1:0]   t;
    logic [T_W-1:0]   sr;
    int unsigned      b;
    y  = x;
    r2 = '0;
    dd = '0;
    t  = '0;
    sr = '0;
    b  = 0;
    if (i < DIV_BITS) begin
      for (int s = 0; s < 6; s++) begin
        r2 = {x.rem[s], 1'b0};
        dd = {1'b0, x.den[s/2]};
        if (r2 >= dd) begin
          y.rem[s] = DEN_W'(r2 - dd);
          y.q[s]   = {x.q[s][DIV_BITS-2:0], 1'b1};
        end else begin
          y.rem[s] = r2[DEN_W-1:0];
          y.q[s]   = {x.q[s][DIV_BITS-2:0], 1'b0};
        end
      end
    end
    if (i < DIST_W) begin
      b  = DIST_W - 1 - i;
      t  = (T_W'(x.root) << (b + 1)) + (T_W'(1) << (2 * b));
      sr = T_W'(x.srem);
      if (sr >= t) begin
        y.srem = SUM_W'(sr - t);
        y.root = x.root | (DIST_W'(1) << b);
      end
    end
    return y;
  endfunction

  item_t stg [N];
  item_t nxt [N];
  logic [N-1:0] v, e;

  always_comb begin
    e[N-1] = !v[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      e[k] = !v[k] || e[k+1];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign nxt[i] = step(in_item, i);
    end else begin : g_rest
      assign nxt[i] = step(stg[i-1], i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (e[0]) v[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (e[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (e[k]) stg[k] <= nxt[k];
    end
  end

  assign in_ready  = e[0];
  assign out_valid = v[N-1];
  assign out_item  = stg[N-1];

endmodule

### rtl/rvil_back.sv
module rvil_back
  import rvil_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  item_t            in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [LEN_W-1:0] segment_length,
  output logic             status
);

  localparam int DLO_W = 17;
  localparam int DHI_W = DIST_W - DLO_W;
  localparam int PLO_W = PAR_W + DLO_W;
  localparam int PHI_W = PAR_W + DHI_W;
  localparam int TOT_W = PAR_W + DIST_W;

  typedef struct packed {
    logic                     idx_bad;
    logic                     ok;
    logic [2:0]               moving;
    logic [2:0][PAR_W-1:0]    mn;
    logic [2:0][PAR_W-1:0]    mx;
    logic [DIST_W-1:0]        root;
  } b1_t;

  typedef struct packed {
    logic                     idx_bad;
    logic                     ok;
    logic [PAR_W-1:0]         lo;
    logic [PAR_W-1:0]         hi;
    logic [DIST_W-1:0]        root;
  } b2_t;

  typedef struct packed {
    logic                     idx_bad;
    logic [PAR_W-1:0]         w;
    logic [DIST_W-1:0]        root;
  } b3_t;

  typedef struct packed {
    logic                     idx_bad;
    logic [PLO_W-1:0]         p_lo;
    logic [PHI_W-1:0]         p_hi;
  } b4_t;

  typedef struct packed {
    logic                     status;
    logic [LEN_W-1:0]         len;
  } b5_t;

  logic [4:0] v, e;
  b1_t b1, b1_next;
  b2_t b2, b2_next;
  b3_t b3, b3_next;
  b4_t b4, b4_next;
  b5_t b5, b5_next;

  always_comb begin
    e[4] = !v[4] || out_ready;
    for (int k = 3; k >= 0; k--) begin
      e[k] = !v[k] || e[k+1];
    end
  end

  assign in_ready       = e[0];
  assign out_valid      = v[4];
  assign segment_length = b5.len;
  assign status         = b5.status;

  always_comb begin
    logic [5:0][PAR_W-1:0] p;
    for (int s = 0; s < 6; s++) begin
      priority if (in_item.zero[s]) p[s] = '0;
      else if (in_item.one[s])      p[s] = ONE_Q;
      else                          p[s] = {1'b0, in_item.q[s]};
    end
    for (int a = 0; a < 3; a++) begin
      b1_next.mn[a] = (p[2*a] < p[2*a+1]) ? p[2*a] : p[2*a+1];
      b1_next.mx[a] = (p[2*a] < p[2*a+1]) ? p[2*a+1] : p[2*a];
    end
    b1_next.idx_bad = in_item.idx_bad;
    b1_next.moving  = in_item.moving;
    b1_next.root    = in_item.root;
    b1_next.ok      = !in_item.idx_bad && (|in_item.moving)
                      && (&(in_item.moving | in_item.stat_ok));
  end

  always_comb begin
    b2_next.idx_bad = b1.idx_bad;
    b2_next.ok      = b1.ok;
    b2_next.root    = b1.root;
    b2_next.lo      = '0;
    b2_next.hi      = ONE_Q;
    for (int a = 0; a < 3; a++) begin
      if (b1.moving[a] && b1.mn[a] > b2_next.lo) b2_next.lo = b1.mn[a];
      if (b1.moving[a] && b1.mx[a] < b2_next.hi) b2_next.hi = b1.mx[a];
    end
  end

  always_comb begin
    b3_next.idx_bad = b2.idx_bad;
    b3_next.root    = b2.root;
    b3_next.w       = (b2.ok && b2.lo < b2.hi) ? b2.hi - b2.lo : '0;
  end

  always_comb begin
    b4_next.idx_bad = b3.idx_bad;
    b4_next.p_lo    = PLO_W'(b3.w) * PLO_W'(b3.root[DLO_W-1:0]);
    b4_next.p_hi    = PHI_W'(b3.w) * PHI_W'(b3.root[DIST_W-1:DLO_W]);
  end

  always_comb begin
    logic [TOT_W-1:0] total;
    total = TOT_W'(b4.p_lo) + (TOT_W'(b4.p_hi) << DLO_W);
    b5_next.status = b4.idx_bad;
    b5_next.len    = (|total[TOT_W-1:FRAC_BITS+LEN_W]) ? '1
                     : total[FRAC_BITS+LEN_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (e[0]) v[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        if (e[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e[0]) b1 <= b1_next;
    if (e[1]) b2 <= b2_next;
    if (e[2]) b3 <= b3_next;
    if (e[3]) b4 <= b4_next;
    if (e[4]) b5 <= b5_next;
  end

endmodule
